### design/lswc_pkg.sv
// ----------------------------------------------------------------------------
// lswc_pkg
// Shared codes and controller/datapath handshake types for the line segment
// window clipper.
// ----------------------------------------------------------------------------
package lswc_pkg;

  // Outcode bits
  localparam logic [3:0] CODE_LEFT   = 4'd1;
  localparam logic [3:0] CODE_RIGHT  = 4'd2;
  localparam logic [3:0] CODE_BOTTOM = 4'd4;
  localparam logic [3:0] CODE_TOP    = 4'd8;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEFT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_RIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_BOTTOM = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_TOP    = 2'd3;

  // Clip step limit
  localparam int unsigned STEP_W = 3;
  localparam logic [STEP_W-1:0] MAX_CLIP_STEPS = 3'd4;

  typedef struct packed {
    logic load;      // capture a new segment
    logic setup;     // pick the edge and register the intersection operands
    logic mul;       // form the product, arm the divider
    logic div_step;  // one restoring division step
    logic update;    // move the endpoint onto the edge
    logic out_load;  // capture the result into the output register
  } cmd_t;

  typedef struct packed {
    logic both_zero;  // both outcodes clear
    logic share;      // outcodes share a bit
    logic div_last;   // this division step is the final one
  } status_t;

endpackage

### design/line_segment_window_clipper.sv
// ----------------------------------------------------------------------------
// line_segment_window_clipper
// Cohen-Sutherland clipping of one segment against a programmable window.
//
// A segment request enters on in_valid_i/in_ready_o with both endpoints; the
// clipped segment leaves on out_valid_o/out_ready_i with accepted_o, and all
// four coordinates read zero when the segment is rejected. The window lives
// in four registers written through cfg_we_i/cfg_idx_i/cfg_data_i (left,
// right, bottom, top); write them only while no request is in flight.
// Each clip step does operand setup, one multiply, a divide by the
// one-bit-per-cycle restoring divider over the 2W+2-bit quotient
// (W = COORD_WIDTH) and an update; a segment takes zero to four clip
// steps. One request is worked on at a time and in_ready_o comes
// back at the same edge that captures the result.
// The output register holds the result while the receiver stalls; the next
// request is taken and clipped meanwhile, and waits for the register to free.
// Reset restores the window to left = bottom = 0, right = top = max positive
// and empties the output register.
// ----------------------------------------------------------------------------
module line_segment_window_clipper #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lswc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [COORD_WIDTH-1:0]         cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [COORD_WIDTH-1:0]  start_x_i,
  input  logic signed [COORD_WIDTH-1:0]  start_y_i,
  input  logic signed [COORD_WIDTH-1:0]  end_x_i,
  input  logic signed [COORD_WIDTH-1:0]  end_y_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           accepted_o,
  output logic signed [COORD_WIDTH-1:0]  clipped_start_x_o,
  output logic signed [COORD_WIDTH-1:0]  clipped_start_y_o,
  output logic signed [COORD_WIDTH-1:0]  clipped_end_x_o,
  output logic signed [COORD_WIDTH-1:0]  clipped_end_y_o
);
  import lswc_pkg::*;

  cmd_t    cmd;
  status_t status;

  lswc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  lswc_dp #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .start_x_i         (start_x_i),
    .start_y_i         (start_y_i),
    .end_x_i           (end_x_i),
    .end_y_i           (end_y_i),
    .cmd_i             (cmd),
    .status_o          (status),
    .accepted_o        (accepted_o),
    .clipped_start_x_o (clipped_start_x_o),
    .clipped_start_y_o (clipped_start_y_o),
    .clipped_end_x_o   (clipped_end_x_o),
    .clipped_end_y_o   (clipped_end_y_o)
  );

endmodule

### design/lswc_ctrl.sv
// ----------------------------------------------------------------------------
// lswc_ctrl
// Sequencer for the clipper: accepts a segment, runs up to four clip steps
// (multiply, serial divide, update) and hands the result to the output stage.
// ----------------------------------------------------------------------------
module lswc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  lswc_pkg::status_t status_i,
  output lswc_pkg::cmd_t    cmd_o
);
  import lswc_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CHECK  = 3'd1;
  localparam logic [2:0] ST_MUL    = 3'd2;
  localparam logic [2:0] ST_DIV    = 3'd3;
  localparam logic [2:0] ST_UPDATE = 3'd4;
  localparam logic [2:0] ST_FINISH = 3'd5;

  logic [2:0]        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              out_valid_q, out_valid_d;
  logic              finish;

  assign finish = status_i.both_zero || status_i.share || (step_q == MAX_CLIP_STEPS);

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          step_d     = '0;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (finish) begin
          state_d = ST_FINISH;
        end else begin
          cmd_o.setup = 1'b1;
          state_d     = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        step_d       = step_q + 1'b1;
        state_d      = ST_CHECK;
      end
      ST_FINISH: begin
        // hold while the previous result is still waiting
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

### design/lswc_dp.sv
// ----------------------------------------------------------------------------
// lswc_dp
// Clipper datapath: window registers, endpoint registers, outcodes, edge
// operand setup, one multiplier, a restoring divider and the output register.
// ----------------------------------------------------------------------------
module lswc_dp #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [lswc_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [COORD_WIDTH-1:0]                cfg_data_i,
  input  logic signed [COORD_WIDTH-1:0]         start_x_i,
  input  logic signed [COORD_WIDTH-1:0]         start_y_i,
  input  logic signed [COORD_WIDTH-1:0]         end_x_i,
  input  logic signed [COORD_WIDTH-1:0]         end_y_i,
  input  lswc_pkg::cmd_t                        cmd_i,
  output lswc_pkg::status_t                     status_o,
  output logic                                  accepted_o,
  output logic signed [COORD_WIDTH-1:0]         clipped_start_x_o,
  output logic signed [COORD_WIDTH-1:0]         clipped_start_y_o,
  output logic signed [COORD_WIDTH-1:0]         clipped_end_x_o,
  output logic signed [COORD_WIDTH-1:0]         clipped_end_y_o
);
  import lswc_pkg::*;

  localparam int unsigned W     = COORD_WIDTH;
  localparam int unsigned DW    = W + 1;       // differences and magnitudes
  localparam int unsigned PW    = 2 * DW;      // product and quotient
  localparam int unsigned RW    = W + 2;       // shifted remainder and final sum
  localparam int unsigned CNT_W = $clog2(PW);

  localparam logic signed [W-1:0]  COORD_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0]  COORD_MIN = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [RW-1:0] SUM_MAX   = {3'b000, {(W-1){1'b1}}};
  localparam logic signed [RW-1:0] SUM_MIN   = {3'b111, {(W-1){1'b0}}};
  localparam logic [CNT_W-1:0]     CNT_LAST  = CNT_W'(PW - 1);

  function automatic logic [3:0] outcode(
    input logic signed [W-1:0] x,
    input logic signed [W-1:0] y,
    input logic signed [W-1:0] l,
    input logic signed [W-1:0] r,
    input logic signed [W-1:0] b,
    input logic signed [W-1:0] t
  );
    logic [3:0] c;
    c = '0;
    if (x < l) begin
      c = c | CODE_LEFT;
    end else if (x > r) begin
      c = c | CODE_RIGHT;
    end
    if (y < b) begin
      c = c | CODE_BOTTOM;
    end else if (y > t) begin
      c = c | CODE_TOP;
    end
    return c;
  endfunction

  function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] v);
    return v[DW-1] ? (~v + DW'(1)) : v;
  endfunction

  // window
  logic signed [W-1:0] win_left_q, win_right_q, win_bottom_q, win_top_q;
  // current endpoints
  logic signed [W-1:0] x1_q, y1_q, x2_q, y2_q;
  // intersection operands
  logic signed [W-1:0] base_q, edge_q;
  logic                axis_y_q, first_q, neg_q, den_zero_q;
  logic [DW-1:0]       mag_num_q, mag_fac_q, mag_den_q;
  // divider
  logic [PW-1:0]       dvd_q;
  logic [DW-1:0]       rem_q;
  logic [CNT_W-1:0]    cnt_q;
  // output register
  logic                acc_q;
  logic signed [W-1:0] out_x1_q, out_y1_q, out_x2_q, out_y2_q;

  logic [3:0]          c1, c2, csel;
  logic signed [W-1:0] edge_s, base_s;
  logic                axis_y_s;
  logic signed [DW-1:0] num_s, fac_s, den_s;
  logic [RW-1:0]       rem_sh;
  logic                ge;
  logic [DW-1:0]       qs;
  logic signed [RW-1:0] sum_s;
  logic signed [W-1:0] res_s, nx_s, ny_s;

  always_comb begin
    c1   = outcode(x1_q, y1_q, win_left_q, win_right_q, win_bottom_q, win_top_q);
    c2   = outcode(x2_q, y2_q, win_left_q, win_right_q, win_bottom_q, win_top_q);
    csel = (c1 != 4'd0) ? c1 : c2;
  end

  assign status_o.both_zero = ((c1 | c2) == 4'd0);
  assign status_o.share     = ((c1 & c2) != 4'd0);
  assign status_o.div_last  = (cnt_q == CNT_LAST);

  // edge selection in the order top, bottom, right, left
  always_comb begin
    if ((csel & CODE_TOP) != 4'd0) begin
      edge_s   = win_top_q;
      axis_y_s = 1'b1;
    end else if ((csel & CODE_BOTTOM) != 4'd0) begin
      edge_s   = win_bottom_q;
      axis_y_s = 1'b1;
    end else if ((csel & CODE_RIGHT) != 4'd0) begin
      edge_s   = win_right_q;
      axis_y_s = 1'b0;
    end else begin
      edge_s   = win_left_q;
      axis_y_s = 1'b0;
    end
    if (axis_y_s) begin
      base_s = x1_q;
      num_s  = {edge_s[W-1], edge_s} - {y1_q[W-1], y1_q};
      fac_s  = {x2_q[W-1], x2_q} - {x1_q[W-1], x1_q};
      den_s  = {y2_q[W-1], y2_q} - {y1_q[W-1], y1_q};
    end else begin
      base_s = y1_q;
      num_s  = {edge_s[W-1], edge_s} - {x1_q[W-1], x1_q};
      fac_s  = {y2_q[W-1], y2_q} - {y1_q[W-1], y1_q};
      den_s  = {x2_q[W-1], x2_q} - {x1_q[W-1], x1_q};
    end
  end

  // restoring division step
  always_comb begin
    rem_sh = {rem_q, dvd_q[PW-1]};
    ge     = (rem_sh >= {1'b0, mag_den_q});
  end

  // saturate the quotient, apply the sign, clamp to the coordinate range
  always_comb begin
    if (den_zero_q) begin
      qs = '0;
    end else if (|dvd_q[PW-1:W]) begin
      qs = {1'b1, {W{1'b0}}};
    end else begin
      qs = {1'b0, dvd_q[W-1:0]};
    end
    if (neg_q) begin
      sum_s = {{2{base_q[W-1]}}, base_q} - {1'b0, qs};
    end else begin
      sum_s = {{2{base_q[W-1]}}, base_q} + {1'b0, qs};
    end
    if (sum_s > SUM_MAX) begin
      res_s = COORD_MAX;
    end else if (sum_s < SUM_MIN) begin
      res_s = COORD_MIN;
    end else begin
      res_s = sum_s[W-1:0];
    end
    if (axis_y_q) begin
      nx_s = res_s;
      ny_s = edge_q;
    end else begin
      nx_s = edge_q;
      ny_s = res_s;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_left_q   <= '0;
      win_right_q  <= COORD_MAX;
      win_bottom_q <= '0;
      win_top_q    <= COORD_MAX;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WINDOW_LEFT:   win_left_q   <= cfg_data_i;
        CFG_WINDOW_RIGHT:  win_right_q  <= cfg_data_i;
        CFG_WINDOW_BOTTOM: win_bottom_q <= cfg_data_i;
        CFG_WINDOW_TOP:    win_top_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x1_q <= start_x_i;
      y1_q <= start_y_i;
      x2_q <= end_x_i;
      y2_q <= end_y_i;
    end else if (cmd_i.update) begin
      if (first_q) begin
        x1_q <= nx_s;
        y1_q <= ny_s;
      end else begin
        x2_q <= nx_s;
        y2_q <= ny_s;
      end
    end

    if (cmd_i.setup) begin
      base_q     <= base_s;
      edge_q     <= edge_s;
      axis_y_q   <= axis_y_s;
      first_q    <= (c1 != 4'd0);
      neg_q      <= num_s[DW-1] ^ fac_s[DW-1] ^ den_s[DW-1];
      den_zero_q <= (den_s == '0);
      mag_num_q  <= mag(num_s);
      mag_fac_q  <= mag(fac_s);
      mag_den_q  <= mag(den_s);
    end

    if (cmd_i.mul) begin
      dvd_q <= mag_num_q * mag_fac_q;
      rem_q <= '0;
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[PW-2:0], ge};
      rem_q <= ge ? DW'(rem_sh - {1'b0, mag_den_q}) : DW'(rem_sh);
      cnt_q <= cnt_q + 1'b1;
    end

    if (cmd_i.out_load) begin
      acc_q    <= status_o.both_zero;
      out_x1_q <= status_o.both_zero ? x1_q : '0;
      out_y1_q <= status_o.both_zero ? y1_q : '0;
      out_x2_q <= status_o.both_zero ? x2_q : '0;
      out_y2_q <= status_o.both_zero ? y2_q : '0;
    end
  end

  assign accepted_o        = acc_q;
  assign clipped_start_x_o = out_x1_q;
  assign clipped_start_y_o = out_y1_q;
  assign clipped_end_x_o   = out_x2_q;
  assign clipped_end_y_o   = out_y2_q;

endmodule

### design/lswc_checker.sv
// ----------------------------------------------------------------------------
// lswc_checker
// Port-level checks for the line segment window clipper, bound to the top.
// ----------------------------------------------------------------------------
module lswc_checker #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic                           accepted_o,
  input logic signed [COORD_WIDTH-1:0]  clipped_start_x_o,
  input logic signed [COORD_WIDTH-1:0]  clipped_start_y_o,
  input logic signed [COORD_WIDTH-1:0]  clipped_end_x_o,
  input logic signed [COORD_WIDTH-1:0]  clipped_end_y_o
);

  // a stalled result stays valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable({accepted_o, clipped_start_x_o,
      clipped_start_y_o, clipped_end_x_o, clipped_end_y_o}))
    else $error("result payload changed while stalled");

  // a rejected segment reports zero coordinates
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !accepted_o |-> clipped_start_x_o == '0 && clipped_start_y_o == '0
      && clipped_end_x_o == '0 && clipped_end_y_o == '0)
    else $error("rejected segment with nonzero coordinates");

  // a taken request closes the input until its result is captured
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input reopened right after a request");

  // a new result is captured only while the input is closed
  a_capture_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result appeared while the block was idle");

endmodule

bind line_segment_window_clipper lswc_checker #(
  .COORD_WIDTH (COORD_WIDTH)
) u_lswc_checker (.*);

### verif/line_segment_window_clipper_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// line_segment_window_clipper_tb
// Drives segments through the clipper under a series of windows (reset,
// typical, single point, inverted, full range, random) and checks every
// clipped result against an in-bench Cohen-Sutherland predictor. Random
// idle cycles are placed on both the request and the result side. One long
// result stall backs the clipper up, and one stretch runs with no idling.
// ----------------------------------------------------------------------------
module line_segment_window_clipper_tb;
  import lswc_pkg::*;

  localparam int COORD_W = 16;
  localparam longint COORD_MAX = (64'sd1 <<< (COORD_W - 1)) - 1;
  localparam longint COORD_MIN = -COORD_MAX - 1;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 160;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
  } segment_t;

  typedef struct packed {
    logic   accepted;
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
  } clip_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = CFG_WINDOW_LEFT;
  logic [COORD_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  coord_t start_x_i = '0;
  coord_t start_y_i = '0;
  coord_t end_x_i = '0;
  coord_t end_y_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic accepted_o;
  coord_t clipped_start_x_o;
  coord_t clipped_start_y_o;
  coord_t clipped_end_x_o;
  coord_t clipped_end_y_o;

  // Window as the bench believes it is programmed
  longint win_left = 0;
  longint win_right = COORD_MAX;
  longint win_bottom = 0;
  longint win_top = COORD_MAX;

  segment_t pending_segments[$];
  clip_t    expected_clips[$];

  int  n_queued = 0;
  int  n_results = 0;
  int  n_inside = 0;
  int  n_errors = 0;
  int  n_windows = 0;
  int  tx_idle_pct = 37;
  int  rx_idle_pct = 37;
  logic req_taken = 1'b0;
  logic rx_hold_req = 1'b0;
  int  rx_hold_count = 0;

  line_segment_window_clipper #(
    .COORD_WIDTH(COORD_W)
  ) DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .start_x_i         (start_x_i),
    .start_y_i         (start_y_i),
    .end_x_i           (end_x_i),
    .end_y_i           (end_y_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .accepted_o        (accepted_o),
    .clipped_start_x_o (clipped_start_x_o),
    .clipped_start_y_o (clipped_start_y_o),
    .clipped_end_x_o   (clipped_end_x_o),
    .clipped_end_y_o   (clipped_end_y_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic logic [3:0] region_code(longint x, longint y);
    logic [3:0] c;
    c = 4'b0000;
    if (x < win_left) c |= CODE_LEFT;
    else if (x > win_right) c |= CODE_RIGHT;
    if (y < win_bottom) c |= CODE_BOTTOM;
    else if (y > win_top) c |= CODE_TOP;
    return c;
  endfunction

  // base + trunc(num * fac / den), saturated to the coordinate range
  function automatic longint intercept(longint base, longint num, longint fac, longint den);
    longint q;
    longint r;
    logic neg;
    if (den == 0) return base;
    neg = ((num < 0) != (fac < 0)) != (den < 0);
    q = ((num < 0 ? -num : num) * (fac < 0 ? -fac : fac)) / (den < 0 ? -den : den);
    if (q > (64'sd1 <<< 40)) q = 64'sd1 <<< 40;
    r = neg ? base - q : base + q;
    if (r > COORD_MAX) r = COORD_MAX;
    if (r < COORD_MIN) r = COORD_MIN;
    return r;
  endfunction

  function automatic clip_t clip_segment(segment_t s);
    longint x1, y1, x2, y2, nx, ny;
    logic [3:0] c1, c2, c;
    logic done;
    int step;
    clip_t res;
    x1 = s.sx;
    y1 = s.sy;
    x2 = s.ex;
    y2 = s.ey;
    c1 = region_code(x1, y1);
    c2 = region_code(x2, y2);
    done = 1'b0;
    for (step = 0; step < int'(MAX_CLIP_STEPS); step++) begin
      if ((c1 | c2) == 4'b0000 || (c1 & c2) != 4'b0000) done = 1'b1;
      if (!done) begin
        c = (c1 != 4'b0000) ? c1 : c2;
        if ((c & CODE_TOP) != 4'b0000) begin
          ny = win_top;
          nx = intercept(x1, win_top - y1, x2 - x1, y2 - y1);
        end else if ((c & CODE_BOTTOM) != 4'b0000) begin
          ny = win_bottom;
          nx = intercept(x1, win_bottom - y1, x2 - x1, y2 - y1);
        end else if ((c & CODE_RIGHT) != 4'b0000) begin
          nx = win_right;
          ny = intercept(y1, win_right - x1, y2 - y1, x2 - x1);
        end else begin
          nx = win_left;
          ny = intercept(y1, win_left - x1, y2 - y1, x2 - x1);
        end
        // move whichever endpoint was outside, first one first
        if (c1 != 4'b0000) begin
          x1 = nx;
          y1 = ny;
          c1 = region_code(x1, y1);
        end else begin
          x2 = nx;
          y2 = ny;
          c2 = region_code(x2, y2);
        end
      end
    end
    res = '0;
    if ((c1 | c2) == 4'b0000) begin
      res.accepted = 1'b1;
      res.sx = x1[COORD_W-1:0];
      res.sy = y1[COORD_W-1:0];
      res.ex = x2[COORD_W-1:0];
      res.ey = y2[COORD_W-1:0];
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : request_sampler
    req_taken <= rst_ni && in_valid_i && in_ready_o;
    if (rst_ni && in_valid_i && in_ready_o)
      expected_clips.push_back(clip_segment({start_x_i, start_y_i, end_x_i, end_y_i}));
  end

  always @(negedge clk_i) begin : request_driver
    segment_t seg;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || req_taken) begin
      if (pending_segments.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        seg = pending_segments.pop_front();
        start_x_i <= seg.sx;
        start_y_i <= seg.sy;
        end_x_i <= seg.ex;
        end_y_i <= seg.ey;
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result side
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin : result_receiver
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (rx_hold_req && rx_hold_count < RX_HOLD_CYCLES) begin
      // hold off so the clipper backs up and stalls its input
      rx_hold_count <= rx_hold_count + 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  task automatic compare_field(string name, logic signed [31:0] want,
                               logic signed [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      n_errors++;
    end
  endtask

  always @(posedge clk_i) begin : result_monitor
    clip_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_results++;
      if (accepted_o === 1'b1) n_inside++;
      if (expected_clips.size() == 0) begin
        $error("clipped segment returned with no request outstanding");
        n_errors++;
      end else begin
        want = expected_clips.pop_front();
        compare_field("accepted", want.accepted, accepted_o);
        compare_field("clipped_start_x", want.sx, clipped_start_x_o);
        compare_field("clipped_start_y", want.sy, clipped_start_y_o);
        compare_field("clipped_end_x", want.ex, clipped_end_x_o);
        compare_field("clipped_end_y", want.ey, clipped_end_y_o);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  function automatic longint any_coord();
    coord_t c;
    c = coord_t'($urandom_range(0, 65535));
    return c;
  endfunction

  // Mostly near the window span, sometimes anywhere
  function automatic longint pick_coord(longint lo, longint hi);
    longint a, b, span, v;
    a = (lo < hi) ? lo : hi;
    b = (lo < hi) ? hi : lo;
    span = (b - a) / 2 + 8;
    if ($urandom_range(0, 3) == 0) return any_coord();
    v = a - span + longint'($urandom_range(0, int'(b - a + 2 * span)));
    if (v > COORD_MAX) v = COORD_MAX;
    if (v < COORD_MIN) v = COORD_MIN;
    return v;
  endfunction

  task automatic queue_segment(longint sx, longint sy, longint ex, longint ey);
    pending_segments.push_back({sx[COORD_W-1:0], sy[COORD_W-1:0],
                                ex[COORD_W-1:0], ey[COORD_W-1:0]});
    n_queued++;
  endtask

  task automatic queue_random(int count);
    int i;
    for (i = 0; i < count; i++)
      queue_segment(pick_coord(win_left, win_right), pick_coord(win_bottom, win_top),
                    pick_coord(win_left, win_right), pick_coord(win_bottom, win_top));
  endtask

  // Wait until every queued segment has come back, then let the clipper settle
  task automatic drain();
    while (n_results < n_queued) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value[COORD_W-1:0];
    case (idx)
      CFG_WINDOW_LEFT:   win_left = value;
      CFG_WINDOW_RIGHT:  win_right = value;
      CFG_WINDOW_BOTTOM: win_bottom = value;
      CFG_WINDOW_TOP:    win_top = value;
      default: ;
    endcase
  endtask

  task automatic set_window(longint l, longint r, longint b, longint t);
    write_reg(CFG_WINDOW_LEFT, l);
    write_reg(CFG_WINDOW_RIGHT, r);
    write_reg(CFG_WINDOW_BOTTOM, b);
    write_reg(CFG_WINDOW_TOP, t);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    n_windows++;
  endtask

  initial begin : stimulus
    int k;
    longint xlo, xhi, ylo, yhi;

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset window: corners of the range, crossings of left and bottom
    queue_segment(0, 0, 32767, 32767);
    queue_segment(-32768, -32768, 32767, 32767);
    queue_segment(-32768, -32768, -1, -1);
    queue_segment(32767, -32768, -32768, 32767);
    queue_segment(-100, 50, 100, 50);
    queue_segment(50, -100, 50, 100);
    drain();

    // Typical window, with one long receiver stall
    set_window(-1000, 1000, -500, 700);
    queue_segment(-2000, -2000, 2000, 2000);
    queue_segment(0, 0, 100, -100);
    queue_segment(1500, 0, 1500, 300);
    queue_segment(0, 0, 3000, 100);
    queue_segment(-1500, 800, 0, 0);
    queue_segment(5, 5, 5, 5);
    queue_segment(-1001, 701, -1001, 701);
    queue_segment(-1000, -500, 1000, 700);
    queue_segment(-2000, 200, 200, -3000);
    rx_hold_req = 1'b1;
    queue_random(80);
    drain();

    // Single-point window
    set_window(5, 5, -7, -7);
    queue_segment(5, -7, 5, -7);
    queue_segment(0, -12, 10, -2);
    queue_segment(-32768, 32767, 32767, -32768);
    queue_random(30);
    drain();

    // Inverted window: no point is ever inside, step limit comes into play
    set_window(100, -100, 100, -100);
    queue_segment(0, 0, 0, 0);
    queue_segment(-50, -200, 150, 200);
    queue_segment(-32768, -32768, 32767, 32767);
    queue_segment(32767, 0, -32768, 0);
    queue_random(40);
    drain();

    // Full-range window, no idling on either side
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_window(-32768, 32767, -32768, 32767);
    queue_segment(-32768, -32768, 32767, 32767);
    queue_segment(32767, -32768, -32768, 32767);
    queue_random(30);
    drain();
    tx_idle_pct = 37;
    rx_idle_pct = 37;

    // Extreme inverted window, intersections tend to saturate
    set_window(32767, -32768, 32767, -32768);
    queue_random(20);
    drain();

    // Random windows, the last one unordered
    for (k = 0; k < 4; k++) begin
      if (k == 3) begin
        set_window(any_coord(), any_coord(), any_coord(), any_coord());
      end else begin
        xlo = any_coord();
        xhi = xlo + $urandom_range(0, 3000);
        if (xhi > COORD_MAX) xhi = COORD_MAX;
        ylo = any_coord();
        yhi = ylo + $urandom_range(0, 3000);
        if (yhi > COORD_MAX) yhi = COORD_MAX;
        set_window(xlo, xhi, ylo, yhi);
      end
      queue_random(50);
      drain();
    end

    repeat (SETTLE_CYCLES) @(negedge clk_i);
    $display("Clipped %0d segments under %0d programmed windows plus the reset window;",
             n_results, n_windows);
    $display("%0d came back inside the window and %0d were rejected.",
             n_inside, n_results - n_inside);
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : watchdog
    #1_200_000;
    $display("Timed out with %0d of %0d segments returned", n_results, n_queued);
    $display("Test completed with failures");
    $finish;
  end

endmodule

### sim.f
design/lswc_pkg.sv
design/lswc_ctrl.sv
design/lswc_dp.sv
design/line_segment_window_clipper.sv
design/lswc_checker.sv
verif/line_segment_window_clipper_tb.sv
